// ----- design/mau_pkg.sv -----
package mau_pkg;

   // Field widths fixed by the request and result formats.
   localparam int POS_W       = 3;
   localparam int FIELD_W     = 32;
   localparam int DIM_REG_W   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Request types.
   localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
   localparam logic [1:0] REQ_RUN         = 2'd2;

   // Operation codes.
   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_SUB     = 3'd1;
   localparam logic [2:0] OP_SCALE   = 3'd2;
   localparam logic [2:0] OP_PRODUCT = 3'd3;
   localparam logic [2:0] OP_SUM     = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DIM_ERR   = 2'd1;
   localparam logic [1:0] STATUS_INDEX_ERR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ROWS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COLS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_ROWS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_COLS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 3'd5;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd1;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [POS_W-1:0]         row_index;
      logic [POS_W-1:0]         col_index;
      logic signed [FIELD_W-1:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]         out_row;
      logic [POS_W-1:0]         out_col;
      logic signed [FIELD_W-1:0] out_value;
      logic [1:0]               status;
      logic                     last_item;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]           op_mode;
      logic [DIM_REG_W-1:0] first_rows;
      logic [DIM_REG_W-1:0] first_cols;
      logic [DIM_REG_W-1:0] second_rows;
      logic [DIM_REG_W-1:0] second_cols;
   } cfg_type;

   // Marks one multiply-accumulate step as it moves down the datapath.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } step_tag_type;

   // Tells the top level to load the result register.
   typedef struct packed {
      logic             load;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [1:0]       status;
      logic             last;
      logic             use_acc;
   } out_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ERROR
   } seq_state_type;

endpackage

// ----- design/mau_ram.sv -----
module mau_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- design/mau_mac.sv -----
module mau_mac #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             op_mode,
   input  logic [DATA_WIDTH-1:0]  rd_a,
   input  logic [DATA_WIDTH-1:0]  rd_b,
   input  logic [DATA_WIDTH-1:0]  scale,
   input  mau_pkg::step_tag_type  tag_in,
   input  logic                   done_clear,
   output logic [DATA_WIDTH-1:0]  acc,
   output logic                   acc_done
);

   import mau_pkg::*;

   step_tag_type          tag0_ff, tag1_ff, tag2_ff;
   logic [DATA_WIDTH-1:0] mul_b;
   logic [63:0]           a_ext, b_ext;
   logic [31:0]           a_lo, a_hi, b_lo, b_hi;
   logic [63:0]           pp_lo_in, pp_lo_ff;
   logic [31:0]           pp_ab_in, pp_ab_ff, pp_ba_in, pp_ba_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic [63:0]           prod_full;
   logic [DATA_WIDTH-1:0] term_in, term_ff;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  done_ff, done_in;

   // Low 64 bits of the product from three 32x32 partial products.
   assign mul_b    = (op_mode == OP_SCALE) ? scale : rd_b;
   assign a_ext    = 64'(rd_a);
   assign b_ext    = 64'(mul_b);
   assign a_lo     = a_ext[31:0];
   assign a_hi     = a_ext[63:32];
   assign b_lo     = b_ext[31:0];
   assign b_hi     = b_ext[63:32];
   assign pp_lo_in = a_lo * b_lo;
   assign pp_ab_in = a_lo * b_hi;
   assign pp_ba_in = a_hi * b_lo;

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_ab_ff <= pp_ab_in;
      pp_ba_ff <= pp_ba_in;
      a_ff     <= rd_a;
      b_ff     <= rd_b;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
   end

   assign prod_full = pp_lo_ff + {pp_ab_ff + pp_ba_ff, 32'd0};

   always_comb begin
      case (op_mode)
         OP_ADD:  term_in = a_ff + b_ff;
         OP_SUB:  term_in = a_ff - b_ff;
         OP_SUM:  term_in = a_ff;
         default: term_in = prod_full[DATA_WIDTH-1:0];
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      done_in = done_ff;
      if (tag2_ff.valid) begin
         acc_in = tag2_ff.first ? term_ff : acc_ff + term_ff;
      end
      if (done_clear) begin
         done_in = 1'b0;
      end else if (tag2_ff.valid && tag2_ff.last) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag0_ff <= tag_in;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         done_ff <= done_in;
      end
   end

   assign acc      = acc_ff;
   assign acc_done = done_ff;

endmodule

// ----- design/mau_seq.sv -----
module mau_seq #(
   parameter int MAX_DIM = 8,
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mau_pkg::req_payload_type req_data,
   input  mau_pkg::cfg_type         cfg,
   input  logic                     out_free,
   input  logic                     acc_done,
   output logic                     wr_first_en,
   output logic                     wr_second_en,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [ADDR_W-1:0]        rd_addr_a,
   output logic [ADDR_W-1:0]        rd_addr_b,
   output mau_pkg::step_tag_type    issue_tag,
   output mau_pkg::out_ctl_type     out_ctl
);

   import mau_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // Zero counts as one, anything above the array size saturates.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] raw);
      if (raw == '0) begin
         return DIM_W'(1);
      end
      if (raw > DIM_REG_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(raw);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
   endfunction

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in, step_ff, step_in;
   logic [1:0]       err_status_ff, err_status_in;
   logic [DIM_W-1:0] ar, ac, br, bc, tgt_rows, tgt_cols;
   logic [IDX_W-1:0] ar_last, ac_last, bc_last, col_end;
   logic             row_last, col_last, step_last, in_range, is_sum;

   assign ar       = eff_dim(cfg.first_rows);
   assign ac       = eff_dim(cfg.first_cols);
   assign br       = eff_dim(cfg.second_rows);
   assign bc       = eff_dim(cfg.second_cols);
   assign ar_last  = IDX_W'(ar - 1'b1);
   assign ac_last  = IDX_W'(ac - 1'b1);
   assign bc_last  = IDX_W'(bc - 1'b1);
   assign col_end  = (cfg.op_mode == OP_PRODUCT) ? bc_last : ac_last;
   assign row_last = (row_ff == ar_last);
   assign col_last = (col_ff == col_end);
   assign step_last = (step_ff == ac_last);
   assign is_sum   = (cfg.op_mode == OP_SUM);

   assign tgt_rows = (req_data.req_type == REQ_LOAD_FIRST) ? ar : br;
   assign tgt_cols = (req_data.req_type == REQ_LOAD_FIRST) ? ac : bc;
   assign in_range = (DIM_REG_W'(req_data.row_index) < DIM_REG_W'(tgt_rows)) &&
                     (DIM_REG_W'(req_data.col_index) < DIM_REG_W'(tgt_cols));

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      step_in       = step_ff;
      err_status_in = err_status_ff;
      req_ready     = 1'b0;
      wr_first_en   = 1'b0;
      wr_second_en  = 1'b0;
      wr_addr       = cell_addr(IDX_W'(req_data.row_index), IDX_W'(req_data.col_index));
      rd_addr_a     = cell_addr(row_ff, col_ff);
      rd_addr_b     = cell_addr(row_ff, col_ff);
      issue_tag     = '0;
      out_ctl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.req_type) inside
                  REQ_LOAD_FIRST, REQ_LOAD_SECOND: begin
                     if (in_range) begin
                        wr_first_en  = (req_data.req_type == REQ_LOAD_FIRST);
                        wr_second_en = (req_data.req_type == REQ_LOAD_SECOND);
                     end else begin
                        err_status_in = STATUS_INDEX_ERR;
                        state_in      = ST_ERROR;
                     end
                  end
                  REQ_RUN: begin
                     row_in  = '0;
                     col_in  = '0;
                     step_in = '0;
                     case (cfg.op_mode) inside
                        OP_ADD, OP_SUB: begin
                           if (ar == br && ac == bc) begin
                              state_in = ST_ISSUE;
                           end else begin
                              err_status_in = STATUS_DIM_ERR;
                              state_in      = ST_ERROR;
                           end
                        end
                        OP_PRODUCT: begin
                           if (ac == br) begin
                              state_in = ST_ISSUE;
                           end else begin
                              err_status_in = STATUS_DIM_ERR;
                              state_in      = ST_ERROR;
                           end
                        end
                        OP_SCALE, OP_SUM: begin
                           state_in = ST_ISSUE;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         ST_ISSUE: begin
            issue_tag.valid = 1'b1;
            case (cfg.op_mode)
               OP_PRODUCT: begin
                  rd_addr_a       = cell_addr(row_ff, step_ff);
                  rd_addr_b       = cell_addr(step_ff, col_ff);
                  issue_tag.first = (step_ff == '0);
                  issue_tag.last  = step_last;
                  step_in         = step_ff + 1'b1;
                  if (step_last) begin
                     state_in = ST_DRAIN;
                  end
               end
               OP_SUM: begin
                  // The whole first matrix accumulates into one result.
                  issue_tag.first = (row_ff == '0) && (col_ff == '0);
                  issue_tag.last  = row_last && col_last;
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  if (row_last && col_last) begin
                     state_in = ST_DRAIN;
                  end
               end
               default: begin
                  issue_tag.first = 1'b1;
                  issue_tag.last  = 1'b1;
                  state_in        = ST_DRAIN;
               end
            endcase
         end

         ST_DRAIN: begin
            if (acc_done && out_free) begin
               out_ctl.load    = 1'b1;
               out_ctl.row     = is_sum ? '0 : POS_W'(row_ff);
               out_ctl.col     = is_sum ? '0 : POS_W'(col_ff);
               out_ctl.status  = STATUS_OK;
               out_ctl.last    = is_sum || (row_last && col_last);
               out_ctl.use_acc = 1'b1;
               step_in         = '0;
               if (is_sum || (row_last && col_last)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end

         ST_ERROR: begin
            if (out_free) begin
               out_ctl.load   = 1'b1;
               out_ctl.status = err_status_ff;
               out_ctl.last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         step_ff       <= '0;
         err_status_ff <= STATUS_OK;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         step_ff       <= step_in;
         err_status_ff <= err_status_in;
      end
   end

endmodule

// ----- design/matrix_arithmetic_unit.sv -----
// Matrix arithmetic unit. Two signed matrices of up to MAX_DIM x MAX_DIM
// elements are loaded one element per request into two synchronous memories,
// which read as all zero after reset; the block then applies elementwise add,
// elementwise subtract, scaling of the first matrix, the matrix product or the
// sum of the first matrix on a run request, wrapping at DATA_WIDTH bits.
// Results leave in row-major order on the rsp_ channel, the last one marked,
// and a dimension mismatch or an out-of-range load yields a single error
// result instead. A load that is in range is written to its memory and gives
// no result. During a run the block takes no new request and works one element
// at a time through a single multiply-accumulate datapath fed by one read port
// of each memory: an element accumulates K terms, where K is first_cols for
// the matrix product and 1 for add, subtract and scale; the sum adds
// rows x cols terms into its single result. Between issue and the result
// register lie four registers: the memory read, the partial-product stage, the
// term stage and the accumulator. The result register lets the next request be
// accepted while the last result of a run waits to be taken. There is no
// clearing pass after reset. An unused operation code gives no result.
module matrix_arithmetic_unit #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mau_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mau_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [mau_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mau_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import mau_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   cfg_type                cfg_ff;
   logic signed [31:0]     scale_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   logic [63:0]            elem_ext, scale_ext, acc_ext;
   logic [DATA_WIDTH-1:0]  elem_wide, scale_wide;
   logic                   wr_first_en, wr_second_en;
   logic [ADDR_W-1:0]      wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_WIDTH-1:0]  rd_a, rd_b, acc;
   logic                   acc_done, out_free;
   step_tag_type           issue_tag;
   out_ctl_type            out_ctl;

   // Configuration registers. Users must write only while idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{op_mode: OP_PRODUCT, first_rows: DIM_RESET, first_cols: DIM_RESET,
                       second_rows: DIM_RESET, second_cols: DIM_RESET};
         scale_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OP_MODE:      cfg_ff.op_mode     <= csr_wdata[2:0];
            CSR_FIRST_ROWS:   cfg_ff.first_rows  <= csr_wdata[DIM_REG_W-1:0];
            CSR_FIRST_COLS:   cfg_ff.first_cols  <= csr_wdata[DIM_REG_W-1:0];
            CSR_SECOND_ROWS:  cfg_ff.second_rows <= csr_wdata[DIM_REG_W-1:0];
            CSR_SECOND_COLS:  cfg_ff.second_cols <= csr_wdata[DIM_REG_W-1:0];
            CSR_SCALE_FACTOR: scale_ff           <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Element values and the scale factor are sign-extended or truncated to
   // the internal data width.
   assign elem_ext   = 64'(signed'(req_data.element_value));
   assign elem_wide  = elem_ext[DATA_WIDTH-1:0];
   assign scale_ext  = 64'(scale_ff);
   assign scale_wide = scale_ext[DATA_WIDTH-1:0];

   mau_seq #(
      .MAX_DIM(MAX_DIM)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .cfg          (cfg_ff),
      .out_free     (out_free),
      .acc_done     (acc_done),
      .wr_first_en  (wr_first_en),
      .wr_second_en (wr_second_en),
      .wr_addr      (wr_addr),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .issue_tag    (issue_tag),
      .out_ctl      (out_ctl)
   );

   // Loads and run reads never overlap: the sequencer writes only while idle
   // and reads only during a run, so no forwarding is needed.
   mau_ram #(
      .DEPTH(DEPTH),
      .WIDTH(DATA_WIDTH)
   ) u_first_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_first_en),
      .wr_addr (wr_addr),
      .wr_data (elem_wide),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   mau_ram #(
      .DEPTH(DEPTH),
      .WIDTH(DATA_WIDTH)
   ) u_second_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_second_en),
      .wr_addr (wr_addr),
      .wr_data (elem_wide),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   mau_mac #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .op_mode    (cfg_ff.op_mode),
      .rd_a       (rd_a),
      .rd_b       (rd_b),
      .scale      (scale_wide),
      .tag_in     (issue_tag),
      .done_clear (out_ctl.load && out_ctl.use_acc),
      .acc        (acc),
      .acc_done   (acc_done)
   );

   // Result register. It is free when empty or when its result is being
   // taken in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign acc_ext  = 64'(acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctl.load) begin
         rsp_data_ff.out_row   <= out_ctl.row;
         rsp_data_ff.out_col   <= out_ctl.col;
         rsp_data_ff.out_value <= out_ctl.use_acc ? signed'(acc_ext[31:0]) : '0;
         rsp_data_ff.status    <= out_ctl.status;
         rsp_data_ff.last_item <= out_ctl.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_ctl.load |-> out_free)
      else $error("result register overwritten while still pending");

   // When a new request can be accepted, no finished element is left behind.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !acc_done)
      else $error("accumulated element not delivered before going idle");

   // Every error result closes its run.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> rsp_data.last_item)
      else $error("error result not marked as last");

endmodule

// ----- tb/sv/mau_check_pkg.sv -----
`timescale 1ns / 100ps
package mau_check_pkg;
   import mau_pkg::*;

   localparam int MAX_DIM = 8;

   // Keeps its own copy of both stores and of the registers. It turns every
   // accepted request into the result elements that request must produce.
   class matrix_scoreboard;
      logic [FIELD_W-1:0]   first_store[MAX_DIM*MAX_DIM];
      logic [FIELD_W-1:0]   second_store[MAX_DIM*MAX_DIM];
      logic [2:0]           op_mode;
      logic [DIM_REG_W-1:0] first_rows;
      logic [DIM_REG_W-1:0] first_cols;
      logic [DIM_REG_W-1:0] second_rows;
      logic [DIM_REG_W-1:0] second_cols;
      logic [FIELD_W-1:0]   scale_factor;
      rsp_payload_type      expected_elements[$];
      int unsigned          error_count;
      int unsigned          result_count;

      function new();
         foreach (first_store[n]) begin
            first_store[n]  = '0;
            second_store[n] = '0;
         end
         op_mode      = OP_PRODUCT;
         first_rows   = DIM_RESET;
         first_cols   = DIM_RESET;
         second_rows  = DIM_RESET;
         second_cols  = DIM_RESET;
         scale_factor = '0;
         error_count  = 0;
         result_count = 0;
      endfunction

      // A zero dimension counts as one, anything above the store size as full size.
      function int unsigned clamp_dim(logic [DIM_REG_W-1:0] dim);
         if (dim == 0) return 1;
         if (dim > MAX_DIM) return MAX_DIM;
         return dim;
      endfunction

      function int unsigned pending();
         return expected_elements.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_OP_MODE:      op_mode      = data[2:0];
            CSR_FIRST_ROWS:   first_rows   = data[DIM_REG_W-1:0];
            CSR_FIRST_COLS:   first_cols   = data[DIM_REG_W-1:0];
            CSR_SECOND_ROWS:  second_rows  = data[DIM_REG_W-1:0];
            CSR_SECOND_COLS:  second_cols  = data[DIM_REG_W-1:0];
            CSR_SCALE_FACTOR: scale_factor = data[FIELD_W-1:0];
            default: ;
         endcase
      endfunction

      function void queue_element(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                  logic [FIELD_W-1:0] value, logic [1:0] status,
                                  logic last);
         rsp_payload_type element;
         element.out_row   = row;
         element.out_col   = col;
         element.out_value = value;
         element.status    = status;
         element.last_item = last;
         expected_elements.push_back(element);
      endfunction

      function void note_request(req_payload_type req);
         int unsigned        ar, ac, br, bc, rows, cols, i, j, k;
         logic [FIELD_W-1:0] a, b, acc;
         ar = clamp_dim(first_rows);
         ac = clamp_dim(first_cols);
         br = clamp_dim(second_rows);
         bc = clamp_dim(second_cols);
         case (req.req_type)
            REQ_LOAD_FIRST, REQ_LOAD_SECOND: begin
               rows = (req.req_type == REQ_LOAD_FIRST) ? ar : br;
               cols = (req.req_type == REQ_LOAD_FIRST) ? ac : bc;
               if (req.row_index >= rows || req.col_index >= cols) begin
                  queue_element('0, '0, '0, STATUS_INDEX_ERR, 1'b1);
               end else if (req.req_type == REQ_LOAD_FIRST) begin
                  first_store[req.row_index*MAX_DIM + req.col_index] = req.element_value;
               end else begin
                  second_store[req.row_index*MAX_DIM + req.col_index] = req.element_value;
               end
            end
            REQ_RUN: begin
               case (op_mode)
                  OP_ADD, OP_SUB: begin
                     if (ar != br || ac != bc) begin
                        queue_element('0, '0, '0, STATUS_DIM_ERR, 1'b1);
                     end else begin
                        for (i = 0; i < ar; i++) begin
                           for (j = 0; j < ac; j++) begin
                              a = first_store[i*MAX_DIM + j];
                              b = second_store[i*MAX_DIM + j];
                              acc = (op_mode == OP_ADD) ? a + b : a - b;
                              queue_element(POS_W'(i), POS_W'(j), acc, STATUS_OK,
                                            i == ar - 1 && j == ac - 1);
                           end
                        end
                     end
                  end
                  OP_SCALE: begin
                     for (i = 0; i < ar; i++) begin
                        for (j = 0; j < ac; j++) begin
                           acc = first_store[i*MAX_DIM + j] * scale_factor;
                           queue_element(POS_W'(i), POS_W'(j), acc, STATUS_OK,
                                         i == ar - 1 && j == ac - 1);
                        end
                     end
                  end
                  OP_PRODUCT: begin
                     if (ac != br) begin
                        queue_element('0, '0, '0, STATUS_DIM_ERR, 1'b1);
                     end else begin
                        for (i = 0; i < ar; i++) begin
                           for (j = 0; j < bc; j++) begin
                              acc = '0;
                              for (k = 0; k < ac; k++) begin
                                 acc = acc + first_store[i*MAX_DIM + k] *
                                             second_store[k*MAX_DIM + j];
                              end
                              queue_element(POS_W'(i), POS_W'(j), acc, STATUS_OK,
                                            i == ar - 1 && j == bc - 1);
                           end
                        end
                     end
                  end
                  OP_SUM: begin
                     acc = '0;
                     for (i = 0; i < ar; i++) begin
                        for (j = 0; j < ac; j++) begin
                           acc = acc + first_store[i*MAX_DIM + j];
                        end
                     end
                     queue_element('0, '0, acc, STATUS_OK, 1'b1);
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_elements.size() == 0) begin
            error_count++;
            $error("result with nothing pending: row %0d col %0d value %h status %0d last %0d",
                   got.out_row, got.out_col, got.out_value, got.status, got.last_item);
            return;
         end
         want = expected_elements.pop_front();
         result_count++;
         if (got.out_row !== want.out_row) begin
            error_count++;
            $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
         end
         if (got.out_col !== want.out_col) begin
            error_count++;
            $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
         end
         if (got.out_value !== want.out_value) begin
            error_count++;
            $error("out_value: expected %h, got %h", want.out_value, got.out_value);
         end
         if (got.status !== want.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", want.status, got.status);
         end
         if (got.last_item !== want.last_item) begin
            error_count++;
            $error("last_item: expected %0d, got %0d", want.last_item, got.last_item);
         end
      endfunction
   endclass

endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the matrix arithmetic unit.
//
// The main process drives requests on the req_ channel and writes the
// configuration registers between phases. Every accepted request is handed to
// a scoreboard object, which keeps its own copy of both matrix stores and of
// the registers and queues the result elements that the request must cause.
// A monitor compares every accepted result, field by field, with the oldest
// queued element.
//
// The run opens with a short directed part: operations on the reset setting,
// the extreme element values, loads outside the configured size, an ignored
// request type, every operation, both kinds of dimension mismatch, an unused
// operation code, dimension registers at zero and above the store size, and
// the extreme scale factors. After that, random phases pick an operation,
// shapes and a scale factor, load the matrices (often completely, sometimes a
// few elements) with a little noise mixed in, and issue runs.
module tb;
   import mau_pkg::*;
   import mau_check_pkg::*;

   localparam int CLOCK_HALF_NS    = 6;
   localparam int RESET_CYCLES     = 4;
   localparam int ITEM_TARGET      = 470;
   // Longest stretch the block may still be busy without a pending result.
   localparam int SETTLE_CYCLES    = 96;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 5000000;

   // Request type and operation codes that the package leaves unnamed.
   localparam logic [1:0] REQ_IGNORED    = 2'd3;
   localparam logic [2:0] OP_UNUSED_LOW  = 3'd5;
   localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   matrix_scoreboard sb;

   // Idling controls; the main process sets gap_max and stall_pct per phase.
   int unsigned gap_max     = 3;
   int unsigned stall_pct   = 30;
   int unsigned burst_left  = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned hold_count  = 0;
   int unsigned streak_left = 0;
   bit          streak_ready = 1'b1;

   int unsigned item_count    = 0;
   int unsigned run_count     = 0;
   int unsigned ignored_count = 0;
   int unsigned config_count  = 0;
   int unsigned cycle_count   = 0;

   always #(CLOCK_HALF_NS) clock = ~clock;

   matrix_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Run guard. A run that never drains its expectations ends up here too.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("no completion after %0d cycles, %0d results still pending",
                cycle_count, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result monitor. Outputs are sampled at the edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         sb.check_result(rsp_data);
      end
   end

   // Result receiver. A long hold-off, when requested, is counted here; the
   // rest of the time the receiver alternates between streaks of ready and
   // streaks of stall whose mix follows stall_pct.
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left    = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
         hold_count++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_pct == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         if (streak_left == 0) begin
            streak_ready = ($urandom_range(0, 99) >= stall_pct);
            streak_left  = streak_ready ? $urandom_range(1, 16) : $urandom_range(1, 6);
         end
         streak_left--;
         rsp_ready <= streak_ready;
      end
   end

   function automatic req_payload_type make_request(logic [1:0] kind,
                                                    logic [POS_W-1:0] row,
                                                    logic [POS_W-1:0] col,
                                                    logic [FIELD_W-1:0] value);
      req_payload_type req;
      req.req_type      = kind;
      req.row_index     = row;
      req.col_index     = col;
      req.element_value = value;
      return req;
   endfunction

   // Element values lean on the wrap-around corners.
   function automatic logic [FIELD_W-1:0] random_element();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DIM_REG_W-1:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 8) return DIM_REG_W'($urandom_range(MAX_DIM + 1, 15));
      if (roll < 20) return DIM_REG_W'($urandom_range(5, MAX_DIM));
      return DIM_REG_W'($urandom_range(1, 4));
   endfunction

   // Offers one request and returns at the edge where it is accepted, with
   // valid still high. Bursts of random length are separated by random gaps.
   task automatic send_request(input req_payload_type req);
      int unsigned gap;
      if (gap_max != 0 && burst_left == 0) begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(req);
      if (burst_left > 0) burst_left--;
      if (req.req_type == REQ_IGNORED) ignored_count++;
      else item_count++;
      if (req.req_type == REQ_RUN) run_count++;
   endtask

   // The sender stops and waits until every queued result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Registers change only while the block is idle: all results taken, then a
   // settle time for a run that causes no result.
   task automatic configure(input logic [2:0] op,
                            input logic [DIM_REG_W-1:0] fr, input logic [DIM_REG_W-1:0] fc,
                            input logic [DIM_REG_W-1:0] sr, input logic [DIM_REG_W-1:0] sc,
                            input logic [FIELD_W-1:0] scale);
      logic [CSR_INDEX_W-1:0] regs[6];
      logic [CSR_DATA_W-1:0]  values[6];
      regs[0] = CSR_OP_MODE;      values[0] = CSR_DATA_W'(op);
      regs[1] = CSR_FIRST_ROWS;   values[1] = CSR_DATA_W'(fr);
      regs[2] = CSR_FIRST_COLS;   values[2] = CSR_DATA_W'(fc);
      regs[3] = CSR_SECOND_ROWS;  values[3] = CSR_DATA_W'(sr);
      regs[4] = CSR_SECOND_COLS;  values[4] = CSR_DATA_W'(sc);
      regs[5] = CSR_SCALE_FACTOR; values[5] = scale;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int n = 0; n < 6; n++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[n];
         csr_wdata <= values[n];
         @(posedge clock);
         sb.write_reg(regs[n], values[n]);
      end
      csr_wr_en <= 1'b0;
      config_count++;
   endtask

   // Loads one matrix, either completely in row-major order or at a few random
   // places. Now and then a load outside the configured size or an ignored
   // request type slips in between.
   task automatic load_matrix(input logic [1:0] target, input int unsigned rows,
                              input int unsigned cols);
      int unsigned r, c, n;
      bit          fill;
      fill = ($urandom_range(0, 1) == 1);
      n = fill ? rows * cols : $urandom_range(1, 4);
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            if ((rows < MAX_DIM || cols < MAX_DIM) && $urandom_range(0, 1) == 1) begin
               if (rows < MAX_DIM && (cols == MAX_DIM || $urandom_range(0, 1) == 1)) begin
                  r = $urandom_range(rows, MAX_DIM - 1);
                  c = $urandom_range(0, MAX_DIM - 1);
               end else begin
                  r = $urandom_range(0, MAX_DIM - 1);
                  c = $urandom_range(cols, MAX_DIM - 1);
               end
               send_request(make_request(target, POS_W'(r), POS_W'(c), random_element()));
            end else begin
               send_request(make_request(REQ_IGNORED, POS_W'($urandom_range(0, 7)),
                                         POS_W'($urandom_range(0, 7)), $urandom()));
            end
         end
         if (fill) begin
            r = k / cols;
            c = k % cols;
         end else begin
            r = $urandom_range(0, rows - 1);
            c = $urandom_range(0, cols - 1);
         end
         send_request(make_request(target, POS_W'(r), POS_W'(c), random_element()));
      end
   endtask

   initial begin
      logic [2:0]           op_list[5];
      logic [2:0]           op;
      logic [DIM_REG_W-1:0] fr, fc, sr, sc;
      int unsigned          n_seq;

      op_list[0] = OP_ADD;
      op_list[1] = OP_SUB;
      op_list[2] = OP_SCALE;
      op_list[3] = OP_PRODUCT;
      op_list[4] = OP_SUM;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the reset setting the block multiplies two 1x1
      // matrices; the first run sees the stores as they come out of reset,
      // the second one the most positive times the most negative value.
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      send_request(make_request(REQ_LOAD_FIRST, 3'd0, 3'd0, 32'h7fff_ffff));
      send_request(make_request(REQ_LOAD_SECOND, 3'd0, 3'd0, 32'h8000_0000));
      send_request(make_request(REQ_RUN, 3'd7, 3'd7, 32'hffff_ffff));
      // Loads just outside a 1x1 shape and at the far corner are index errors.
      send_request(make_request(REQ_LOAD_FIRST, 3'd0, 3'd1, 32'h1234_5678));
      send_request(make_request(REQ_LOAD_SECOND, 3'd7, 3'd7, 32'hffff_ffff));
      send_request(make_request(REQ_IGNORED, 3'd5, 3'd2, 32'h5555_aaaa));

      // Full-size add and subtract with sums and differences that wrap.
      configure(OP_ADD, 4'd8, 4'd8, 4'd8, 4'd8, 32'h8000_0000);
      send_request(make_request(REQ_LOAD_FIRST, 3'd7, 3'd7, 32'hffff_ffff));
      send_request(make_request(REQ_LOAD_SECOND, 3'd7, 3'd7, 32'h0000_0001));
      send_request(make_request(REQ_LOAD_FIRST, 3'd0, 3'd7, 32'h8000_0000));
      send_request(make_request(REQ_LOAD_SECOND, 3'd0, 3'd7, 32'h8000_0000));
      send_request(make_request(REQ_LOAD_FIRST, 3'd3, 3'd4, 32'h7fff_ffff));
      send_request(make_request(REQ_LOAD_SECOND, 3'd3, 3'd4, 32'h7fff_ffff));
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      configure(OP_SUB, 4'd8, 4'd8, 4'd8, 4'd8, 32'h8000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));

      // A zero row count acts as one row and fifteen columns act as eight.
      configure(OP_SCALE, 4'd0, 4'd15, 4'd1, 4'd1, 32'h8000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      configure(OP_SCALE, 4'd8, 4'd8, 4'd1, 4'd1, 32'h7fff_ffff);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      configure(OP_SUM, 4'd15, 4'd15, 4'd1, 4'd1, 32'h0000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));

      // Inner dimensions that differ, then shapes that differ.
      configure(OP_PRODUCT, 4'd2, 4'd3, 4'd4, 4'd2, 32'h0000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      configure(OP_SUB, 4'd2, 4'd2, 4'd2, 4'd3, 32'h0000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));

      // An unused operation code runs without any result.
      configure(OP_UNUSED_HIGH, 4'd2, 4'd2, 4'd2, 4'd2, 32'h0000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));
      configure(OP_PRODUCT, 4'd8, 4'd8, 4'd8, 4'd8, 32'h0000_0000);
      send_request(make_request(REQ_RUN, 3'd0, 3'd0, 32'h0000_0000));

      // Random phases. Most shapes are small and mostly compatible, so that
      // runs produce real results; mismatches, unused codes and the clamped
      // dimension values come up now and then.
      while (item_count < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0) begin
            op = 3'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH));
         end else begin
            op = op_list[$urandom_range(0, 4)];
         end
         fr = pick_dim();
         fc = pick_dim();
         sr = pick_dim();
         sc = pick_dim();
         if ((op == OP_ADD || op == OP_SUB) && $urandom_range(0, 99) < 85) begin
            sr = fr;
            sc = fc;
         end else if (op == OP_PRODUCT && $urandom_range(0, 99) < 85) begin
            sr = fc;
         end
         configure(op, fr, fc, sr, sc, random_element());

         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 85);
         // The long hold-off lets the result side back up into the request side.
         // The first random phase always gets one.
         if (hold_count == 0 || config_count % 15 == 0) hold_request = 1'b1;

         n_seq = $urandom_range(1, 3);
         for (int unsigned s = 0; s < n_seq; s++) begin
            load_matrix(REQ_LOAD_FIRST, sb.clamp_dim(fr), sb.clamp_dim(fc));
            load_matrix(REQ_LOAD_SECOND, sb.clamp_dim(sr), sb.clamp_dim(sc));
            send_request(make_request(REQ_RUN, POS_W'($urandom_range(0, 7)),
                                      POS_W'($urandom_range(0, 7)), $urandom()));
            if ($urandom_range(0, 3) == 0) begin
               send_request(make_request(REQ_RUN, POS_W'($urandom_range(0, 7)),
                                         POS_W'($urandom_range(0, 7)), $urandom()));
            end
            if ($urandom_range(0, 3) == 0) wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d runs) plus %0d ignored ones over %0d register settings,",
               item_count, run_count, ignored_count, config_count);
      $display("checked %0d result elements, with %0d long result-side hold-offs.",
               sb.result_count, hold_count);
      if (sb.error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
